// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define VADSR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define VADSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/vadsr_pkg.sv
// Shared types and constants of the ADSR voice block.
`timescale 1ns / 1ps
package vadsr_pkg;
	localparam int LEVEL_FRAC_BITS = 20;
	localparam int SAMPLE_BITS     = 16;
	localparam int MIX_BITS        = 24;
	localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
	localparam int STEP_W          = 20;
	localparam int SUS_W           = 16;
	localparam int VOL_W           = 17;
	localparam int GAIN_W          = LEVEL_W + 1;

	localparam logic [1:0] FUNC_FRAME    = 2'd0;
	localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
	localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;

	localparam logic [2:0] REG_AMP_RATES   = 3'd0;
	localparam logic [2:0] REG_WAVE_RATES  = 3'd1;
	localparam logic [2:0] REG_AMP2_RATES  = 3'd2;
	localparam logic [2:0] REG_WAVE2_RATES = 3'd3;
	localparam logic [2:0] REG_SUSTAIN     = 3'd4;
	localparam logic [2:0] REG_VOLUME      = 3'd5;
	localparam logic [2:0] REG_OSC_ENABLE  = 3'd6;

	typedef enum logic [4:0] {
		PH_DORMANT = 5'b00001,
		PH_ATTACK  = 5'b00010,
		PH_DECAY   = 5'b00100,
		PH_SUSTAIN = 5'b01000,
		PH_RELEASE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       note_on;
		logic       note_off;
		logic       step;
		logic [1:0] idx;
	} env_ctl_t;
endpackage

// File: rtl/vadsr_ser_mac.sv
// Shift-and-add accumulator that consumes one multiplier bit per cycle while en is high.
`timescale 1ns / 1ps
module vadsr_ser_mac #(
	parameter int ACC_W = 40,
	parameter int ADD_W = 25
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clr,
	input  logic                    en,
	input  logic signed [ADD_W-1:0] addend,
	output logic signed [ACC_W-1:0] acc
);
	logic signed [ACC_W-1:0] acc_q;

	// Bits arrive most significant first, so the running sum doubles each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clr) begin
			acc_q <= '0;
		end else if (en) begin
			acc_q <= (acc_q <<< 1) + ACC_W'(addend);
		end
	end

	assign acc = acc_q;
endmodule

// File: rtl/vadsr_env.sv
// Four envelope phases and levels, one stepped per cycle when step is set.
`timescale 1ns / 1ps
module vadsr_env import vadsr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  env_ctl_t           ctl,
	input  logic [STEP_W-1:0]  atk,
	input  logic [STEP_W-1:0]  dec,
	input  logic [STEP_W-1:0]  rel,
	input  logic [SUS_W-1:0]   sus16,
	output logic [LEVEL_W-1:0] level [4],
	output logic               amps_dormant
);
	localparam logic [LEVEL_W:0] ONE = (LEVEL_W+1)'(1) << LEVEL_FRAC_BITS;

	phase_t             phase_q [4];
	logic [LEVEL_W-1:0] level_q [4];

	phase_t             ph_cur, ph_nxt;
	logic [LEVEL_W-1:0] lv_cur, lv_nxt, sus;
	logic [LEVEL_W:0]   sum;
	logic [LEVEL_W-1:0] diff_dn, diff_up;

	always_comb begin
		ph_cur  = phase_q[ctl.idx];
		lv_cur  = level_q[ctl.idx];
		sus     = LEVEL_W'({sus16, {(LEVEL_FRAC_BITS-SUS_W){1'b0}}});
		sum     = {1'b0, lv_cur} + (LEVEL_W+1)'(atk);
		diff_dn = lv_cur - sus;
		diff_up = sus - lv_cur;
		ph_nxt  = ph_cur;
		lv_nxt  = lv_cur;
		unique case (ph_cur)
			PH_ATTACK: begin
				if (sum >= ONE) begin
					lv_nxt = ONE[LEVEL_W-1:0];
					ph_nxt = PH_DECAY;
				end else begin
					lv_nxt = sum[LEVEL_W-1:0];
				end
			end
			PH_DECAY: begin
				if (lv_cur > sus) begin
					if (diff_dn <= LEVEL_W'(dec)) begin
						lv_nxt = sus;
						ph_nxt = PH_SUSTAIN;
					end else begin
						lv_nxt = lv_cur - LEVEL_W'(dec);
					end
				end else if (lv_cur < sus) begin
					if (diff_up <= LEVEL_W'(dec)) begin
						lv_nxt = sus;
						ph_nxt = PH_SUSTAIN;
					end else begin
						lv_nxt = lv_cur + LEVEL_W'(dec);
					end
				end else begin
					ph_nxt = PH_SUSTAIN;
				end
			end
			PH_RELEASE: begin
				if (lv_cur <= LEVEL_W'(rel)) begin
					lv_nxt = '0;
					ph_nxt = PH_DORMANT;
				end else begin
					lv_nxt = lv_cur - LEVEL_W'(rel);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				phase_q[k] <= PH_DORMANT;
				level_q[k] <= '0;
			end
		end else if (ctl.note_on) begin
			for (int k = 0; k < 4; k++) phase_q[k] <= PH_ATTACK;
		end else if (ctl.note_off) begin
			for (int k = 0; k < 4; k++) begin
				if (phase_q[k] != PH_DORMANT) phase_q[k] <= PH_RELEASE;
			end
		end else if (ctl.step) begin
			phase_q[ctl.idx] <= ph_nxt;
			level_q[ctl.idx] <= lv_nxt;
		end
	end

	assign level        = level_q;
	assign amps_dormant = (phase_q[0] == PH_DORMANT) && (phase_q[2] == PH_DORMANT);
endmodule

// File: rtl/voice_adsr_envelope_mixer.sv
// Top level of the synth voice: four ADSR envelopes and a bit-serial stereo mixer.
`timescale 1ns / 1ps
// Channel   Signals                                 Content
// s_*       tvalid tready tdata[79:0] tuser tlast   note events and frame items
// m_*       tvalid tready tdata[95:0] tlast         one result item per frame
// cfg_*     valid ready index[2:0] data[63:0]       register writes
//
// A frame on an active voice is worked through after acceptance in this order: 4
// envelope steps, the serial level-times-volume multiply (one volume bit per
// cycle), the serial sample MAC (one sample bit per cycle) and the load of the
// result, which waits until the output register is free. The input is ready
// again the cycle after the load. An idle-voice frame goes straight to the load,
// and a note event leaves the input ready in the next cycle.
// Only one item is in work at a time; a finished result waits in the output
// register while the next is accepted, and a second finished frame stalls
// until the output register is free.
// arst_n clears all control state and envelopes asynchronously.
module voice_adsr_envelope_mixer import vadsr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // osc1_sample, osc2_sample, left_in, right_in
	input  logic [1:0]  s_tuser,   // func
	input  logic        s_tlast,   // block_end
	output logic        m_tvalid,
	input  logic        m_tready,
	// left_out, right_out, osc1_wave_mix, osc2_wave_mix, voice_busy, five zero bits
	output logic [95:0] m_tdata,
	output logic        m_tlast,   // block_end_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ENV  = 5'b00010,
		ST_GAIN = 5'b00100,
		ST_MIX  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam int MAC_ADD_W = GAIN_W + 3;
	localparam int MAC_ACC_W = SAMPLE_BITS + GAIN_W + 2;
	localparam int G_ACC_W   = LEVEL_W + VOL_W + 1;
	localparam int SHIFT     = SAMPLE_BITS + LEVEL_FRAC_BITS - MIX_BITS;
	localparam int C_W       = MAC_ACC_W - SHIFT;
	localparam int SUM_W     = C_W + 1;

	// Configuration registers.
	logic [59:0]        rates_q [4];
	logic [63:0]        sustain_q;
	logic [VOL_W-1:0]   vol_q;
	logic [1:0]         osc_en_q;

	state_t             state_q;
	logic [4:0]         cnt_q;
	logic               voice_active_q;
	logic               pass_q;
	logic signed [SAMPLE_BITS-1:0] s1_q, s2_q;
	logic signed [MIX_BITS-1:0]    l_q, r_q;
	logic               last_q;

	logic               m_valid_q;
	logic [95:0]        m_data_q;
	logic               m_last_q;

	logic               in_fire;
	env_ctl_t           ctl;
	logic [LEVEL_W-1:0] level [4];
	logic               amps_dormant;
	logic [59:0]        rate_sel;
	logic [SUS_W-1:0]   sus_sel;

	logic                      gain_clr, gain_en, mix_clr, mix_en, vbit, b1, b2;
	logic signed [GAIN_W-1:0]  g1_add, g2_add;
	logic signed [G_ACC_W-1:0] g1_acc, g2_acc;
	logic [GAIN_W-1:0]         g1, g2;
	logic signed [MAC_ADD_W-1:0] mix_add;
	logic signed [MAC_ACC_W-1:0] term;
	logic signed [C_W-1:0]     c;
	logic signed [SUM_W-1:0]   lsum, rsum;
	logic [MIX_BITS-1:0]       lo, ro;
	logic                      out_free;

	localparam logic signed [SUM_W-1:0] HI = SUM_W'((64'sd1 <<< (MIX_BITS-1)) - 1);
	localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) rates_q[k] <= '0;
			sustain_q <= '0;
			vol_q     <= VOL_W'(65536);
			osc_en_q  <= 2'b11;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AMP_RATES:   rates_q[0] <= cfg_data[59:0];
				REG_WAVE_RATES:  rates_q[1] <= cfg_data[59:0];
				REG_AMP2_RATES:  rates_q[2] <= cfg_data[59:0];
				REG_WAVE2_RATES: rates_q[3] <= cfg_data[59:0];
				REG_SUSTAIN:     sustain_q  <= cfg_data;
				REG_VOLUME:      vol_q      <= cfg_data[VOL_W-1:0];
				REG_OSC_ENABLE:  osc_en_q   <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Envelope control: note events act at acceptance, steps run in ST_ENV.
	always_comb begin
		ctl.note_on  = in_fire && (s_tuser == FUNC_NOTE_ON);
		ctl.note_off = in_fire && (s_tuser == FUNC_NOTE_OFF);
		ctl.step     = (state_q == ST_ENV);
		ctl.idx      = cnt_q[1:0];
		rate_sel     = rates_q[cnt_q[1:0]];
		sus_sel      = sustain_q[cnt_q[1:0]*SUS_W +: SUS_W];
	end

	vadsr_env u_env (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.atk          (rate_sel[59:40]),
		.dec          (rate_sel[39:20]),
		.rel          (rate_sel[19:0]),
		.sus16        (sus_sel),
		.level        (level),
		.amps_dormant (amps_dormant)
	);

	// Gain: level times volume, one volume bit per cycle from the top bit down.
	assign gain_clr = (state_q == ST_ENV) && (cnt_q[1:0] == 2'd3);
	assign gain_en  = (state_q == ST_GAIN);
	assign vbit     = vol_q[cnt_q];
	assign g1_add   = vbit ? $signed({1'b0, level[0]}) : '0;
	assign g2_add   = vbit ? $signed({1'b0, level[2]}) : '0;

	vadsr_ser_mac #(.ACC_W(G_ACC_W), .ADD_W(GAIN_W)) u_gain1 (
		.clk(clk), .arst_n(arst_n), .clr(gain_clr), .en(gain_en),
		.addend(g1_add), .acc(g1_acc)
	);
	vadsr_ser_mac #(.ACC_W(G_ACC_W), .ADD_W(GAIN_W)) u_gain2 (
		.clk(clk), .arst_n(arst_n), .clr(gain_clr), .en(gain_en),
		.addend(g2_add), .acc(g2_acc)
	);

	assign g1 = g1_acc[16 +: GAIN_W];
	assign g2 = g2_acc[16 +: GAIN_W];

	// Mix: both samples share one serial MAC; the sign bit carries negative weight.
	assign mix_clr = gain_en && (cnt_q == 5'd0);
	assign mix_en  = (state_q == ST_MIX);
	assign b1      = s1_q[cnt_q[3:0]] && osc_en_q[0];
	assign b2      = s2_q[cnt_q[3:0]] && osc_en_q[1];

	always_comb begin
		mix_add = (b1 ? MAC_ADD_W'($signed({1'b0, g1})) : '0)
		        + (b2 ? MAC_ADD_W'($signed({1'b0, g2})) : '0);
		if (cnt_q[3:0] == 4'(SAMPLE_BITS-1)) mix_add = -mix_add;
	end

	vadsr_ser_mac #(.ACC_W(MAC_ACC_W), .ADD_W(MAC_ADD_W)) u_mix (
		.clk(clk), .arst_n(arst_n), .clr(mix_clr), .en(mix_en),
		.addend(mix_add), .acc(term)
	);

	// Floor shift, add to the accumulator inputs and saturate, or pass the inputs through unchanged for an idle voice.
	always_comb begin
		c    = term[MAC_ACC_W-1:SHIFT];
		lsum = SUM_W'(l_q) + SUM_W'(c);
		rsum = SUM_W'(r_q) + SUM_W'(c);
		if (pass_q) begin
			lo = l_q;
			ro = r_q;
		end else begin
			lo = (lsum > HI) ? HI[MIX_BITS-1:0] : (lsum < LO) ? LO[MIX_BITS-1:0]
			   : lsum[MIX_BITS-1:0];
			ro = (rsum > HI) ? HI[MIX_BITS-1:0] : (rsum < LO) ? LO[MIX_BITS-1:0]
			   : rsum[MIX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			voice_active_q <= 1'b0;
			pass_q         <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			// A new result fills an empty output register or replaces the one taken in the same cycle.
			if ((state_q == ST_DONE) && out_free) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_tuser == FUNC_NOTE_ON) begin
							voice_active_q <= 1'b1;
						end else if (s_tuser == FUNC_FRAME) begin
							pass_q  <= !voice_active_q;
							cnt_q   <= '0;
							state_q <= voice_active_q ? ST_ENV : ST_DONE;
						end
					end
				end
				ST_ENV: begin
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= 5'(VOL_W-1);
						state_q <= ST_GAIN;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_GAIN: begin
					if (cnt_q == 5'd0) begin
						cnt_q   <= 5'(SAMPLE_BITS-1);
						state_q <= ST_MIX;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_MIX: begin
					if (cnt_q == 5'd0) state_q <= ST_DONE;
					else cnt_q <= cnt_q - 5'd1;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q   <= ST_IDLE;
						if (!pass_q && amps_dormant) voice_active_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire && (s_tuser == FUNC_FRAME)) begin
			s1_q   <= s_tdata[15:0];
			s2_q   <= s_tdata[31:16];
			l_q    <= s_tdata[55:32];
			r_q    <= s_tdata[79:56];
			last_q <= s_tlast;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_data_q <= {5'd0, !pass_q && !amps_dormant, level[3], level[1], ro, lo};
			m_last_q <= last_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
endmodule

// File: rtl/vadsr_checker.sv
// Port-level checker for the voice block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vadsr_checker import vadsr_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready
);
	`VADSR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`VADSR_ASSERT_NEXT(a_frame_busy, s_tvalid && s_tready && s_tuser == FUNC_FRAME, !s_tready)
	`VADSR_ASSERT_NEXT(a_note_quick, s_tvalid && s_tready && s_tuser == FUNC_NOTE_ON, s_tready)
	`VADSR_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), !$past(s_tready))
endmodule

bind voice_adsr_envelope_mixer vadsr_checker u_vadsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
